// ===== design/sba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg: shared types and codes for the stack bump allocator
// Request and status codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int ADDR_W   = 32;
  localparam int OFFS_W   = 25;
  localparam int ALIGN_W  = 8;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OFFS_W-1:0]   offs_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [ALIGN_W-1:0]  align_t;

  // request codes
  localparam func_t FN_ALLOC      = 3'd0;
  localparam func_t FN_ALLOC_AL   = 3'd1;
  localparam func_t FN_REALLOC    = 3'd2;
  localparam func_t FN_REALLOC_AL = 3'd3;
  localparam func_t FN_FREE       = 3'd4;
  localparam func_t FN_SAVE       = 3'd5;
  localparam func_t FN_RESTORE    = 3'd6;
  localparam func_t FN_RESET      = 3'd7;

  // status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_HEAP      = 3'd1;
  localparam status_t ST_SAVE_FULL = 3'd2;
  localparam status_t ST_RESTORE_EMPTY = 3'd3;
  localparam status_t ST_FREE_OUTSIDE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP  = 1'd1;

  typedef struct packed {
    func_t  func;
    offs_t  request_size;
    align_t alignment;
    addr_t  address;
    align_t prior_adjust;
  } req_t;

endpackage

// ===== design/sba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; read returns old data on collision.
// ----------------------------------------------------------------------------
module sba_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/stack_bump_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bump_allocator: linear bump allocator with a marker stack
// Allocates from a buffer at base_address of capacity bytes; save/restore
// push and pop the current offset on a LIFO of MARKER_DEPTH entries.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high (busy stays low), one per
// cycle. Its result comes out with out_strobe high for one cycle, after the
// request register and the result register; the execute logic between them
// updates the offsets and the marker stack. The receiver cannot stall, so
// results must be captured on the strobe. The stack top is always held ready
// from the marker RAM's registered read, so back-to-back save/restore is
// fine. Configuration writes are registered and must happen while idle.
module stack_bump_allocator #(
  parameter int MARKER_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [sba_pkg::FUNC_W-1:0]         in_func,
  input  logic [sba_pkg::OFFS_W-1:0]         in_request_size,
  input  logic [sba_pkg::ALIGN_W-1:0]        in_alignment,
  input  logic [sba_pkg::ADDR_W-1:0]         in_address,
  input  logic [sba_pkg::ALIGN_W-1:0]        in_prior_adjust,
  output logic                               out_strobe,
  output logic [sba_pkg::STATUS_W-1:0]       out_status,
  output logic [sba_pkg::ADDR_W-1:0]         out_result_address,
  output logic [sba_pkg::ALIGN_W-1:0]        out_adjust,
  output logic [sba_pkg::OFFS_W-1:0]         out_high_water,
  input  logic                               cfg_we,
  input  logic [sba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
  localparam int CW = $clog2(MARKER_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MARKER_DEPTH);

  // configuration
  sba_pkg::addr_t base_r;
  sba_pkg::offs_t cap_r;

  // request register
  logic           ex_valid_r;
  sba_pkg::req_t  req_r;

  // allocator state
  sba_pkg::offs_t cur_r, cur_nxt;
  sba_pkg::offs_t last_r, last_nxt;
  sba_pkg::offs_t peak_r, peak_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  // marker stack
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  sba_pkg::offs_t ram_rdata;
  logic [CW-1:0]  cnt_m1;
  logic           byp_r, byp_nxt;
  sba_pkg::offs_t byp_data_r;
  sba_pkg::offs_t stack_top;

  // result register
  logic             out_strobe_r;
  sba_pkg::status_t status_r, status_nxt;
  sba_pkg::addr_t   res_r, res_nxt;
  sba_pkg::align_t  adj_r, adj_nxt;
  sba_pkg::offs_t   hw_r;

  // datapath
  sba_pkg::align_t align_eff;
  sba_pkg::align_t align_mask;
  logic            aligned;
  logic [25:0]     rsize;
  logic [26:0]     fit_sum;
  logic            fits;
  sba_pkg::addr_t  old_addr;
  logic            use_realloc;
  sba_pkg::addr_t  rel;
  logic            inplace;
  sba_pkg::addr_t  raw;
  sba_pkg::offs_t  new_off;
  sba_pkg::align_t adj_c;
  logic [32:0]     buf_end;
  logic            free_out;

  assign busy = 1'b0;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      cap_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sba_pkg::REG_BASE: base_r <= cfg_wdata;
        sba_pkg::REG_CAP:  cap_r  <= cfg_wdata[sba_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- request beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else begin
      ex_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r.func         <= in_func;
      req_r.request_size <= in_request_size;
      req_r.alignment    <= in_alignment;
      req_r.address      <= in_address;
      req_r.prior_adjust <= in_prior_adjust;
    end
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    align_eff  = (req_r.alignment == '0) ? 8'd1 : req_r.alignment;
    align_mask = align_eff - 8'd1;
    aligned    = (req_r.func == sba_pkg::FN_ALLOC_AL) ||
                 (req_r.func == sba_pkg::FN_REALLOC_AL);
    rsize      = {1'b0, req_r.request_size} + (aligned ? {18'd0, align_eff} : 26'd0);
    fit_sum    = {2'b00, cur_r} + {1'b0, rsize};
    fits       = fit_sum <= {2'b00, cap_r};

    old_addr    = (req_r.func == sba_pkg::FN_REALLOC_AL) ?
                  (req_r.address - {24'd0, req_r.prior_adjust}) : req_r.address;
    use_realloc = ((req_r.func == sba_pkg::FN_REALLOC) ||
                   (req_r.func == sba_pkg::FN_REALLOC_AL)) &&
                  (req_r.address != '0) && (old_addr != '0);
    rel         = old_addr - base_r;
    inplace     = use_realloc && (rel == {7'd0, last_r});

    raw     = base_r + {7'd0, (inplace ? last_r : cur_r)};
    new_off = sba_pkg::OFFS_W'((inplace ? {1'b0, last_r} : {1'b0, cur_r}) + rsize);
    adj_c   = align_eff - (raw[sba_pkg::ALIGN_W-1:0] & align_mask);

    buf_end  = {1'b0, base_r} + {8'd0, cap_r};
    free_out = (req_r.address < base_r) || ({1'b0, req_r.address} >= buf_end);
  end

  assign stack_top = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    cur_nxt    = cur_r;
    last_nxt   = last_r;
    peak_nxt   = peak_r;
    cnt_nxt    = cnt_r;
    status_nxt = sba_pkg::ST_OK;
    res_nxt    = '0;
    adj_nxt    = '0;
    ram_we     = 1'b0;
    if (ex_valid_r) begin
      unique case (req_r.func) inside
        sba_pkg::FN_ALLOC, sba_pkg::FN_ALLOC_AL,
        sba_pkg::FN_REALLOC, sba_pkg::FN_REALLOC_AL: begin
          if (!fits) begin
            status_nxt = sba_pkg::ST_HEAP;
          end else begin
            cur_nxt  = new_off;
            if (use_realloc && !inplace) begin
              last_nxt = cur_r;
            end
            peak_nxt = (new_off > peak_r) ? new_off : peak_r;
            if (aligned) begin
              adj_nxt = adj_c;
              res_nxt = raw + {24'd0, adj_c};
            end else begin
              res_nxt = raw;
            end
          end
        end
        sba_pkg::FN_FREE: begin
          if (free_out) begin
            status_nxt = sba_pkg::ST_FREE_OUTSIDE;
          end
        end
        sba_pkg::FN_SAVE: begin
          if (cnt_r == CNT_FULL) begin
            status_nxt = sba_pkg::ST_SAVE_FULL;
          end else begin
            ram_we   = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            last_nxt = cur_r;
          end
        end
        sba_pkg::FN_RESTORE: begin
          if (cnt_r == '0) begin
            status_nxt = sba_pkg::ST_RESTORE_EMPTY;
          end else begin
            cnt_nxt  = cnt_r - 1'b1;
            cur_nxt  = stack_top;
            last_nxt = stack_top;
          end
        end
        default: begin
          // reset request; peak is kept
          cur_nxt  = '0;
          last_nxt = '0;
          cnt_nxt  = '0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------- marker stack
  // Read address tracks the top after this beat; a push to that same entry
  // is forwarded since the RAM returns old data on a collision.
  assign cnt_m1    = cnt_nxt - 1'b1;
  assign ram_raddr = cnt_m1[AW-1:0];
  assign byp_nxt   = ram_we && (ram_raddr == cnt_r[AW-1:0]);

  sba_ram #(
    .WIDTH (sba_pkg::OFFS_W),
    .DEPTH (MARKER_DEPTH)
  ) u_marker_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (cur_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= byp_nxt;
    end
    byp_data_r <= cur_r;
  end

  // ----------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      last_r <= '0;
      peak_r <= '0;
      cnt_r  <= '0;
    end else begin
      cur_r  <= cur_nxt;
      last_r <= last_nxt;
      peak_r <= peak_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ex_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_valid_r) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      adj_r    <= adj_nxt;
      hw_r     <= peak_nxt;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = status_r;
  assign out_result_address = res_r;
  assign out_adjust         = adj_r;
  assign out_high_water     = hw_r;

endmodule

// ===== test/stack_bump_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bump_allocator_tb: self-checking bench for the stack bump allocator
// Runs a table of hand-picked requests, then about 350 random requests over
// several base/capacity settings, mostly well-formed allocate, realloc and
// save/restore sequences. Every result beat is checked field by field against
// a local model of the allocator state, or against the typed-in result of a typed row.
// ----------------------------------------------------------------------------
module stack_bump_allocator_tb;

  localparam int MARKERS     = 16;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 70;

  // how the address of a request is placed relative to the allocator state
  typedef enum logic [1:0] {AM_ABS, AM_BASE, AM_END, AM_LAST} addr_mode_t;

  typedef struct packed {
    sba_pkg::status_t status;
    sba_pkg::addr_t   addr;
    sba_pkg::align_t  adjust;
    sba_pkg::offs_t   high_water;
  } alloc_result_t;

  typedef struct packed {
    logic          setup;  // program the directed base/capacity first
    logic          typed;  // want holds the typed-in result
    logic [4:0]    reps;
    addr_mode_t    mode;
    sba_pkg::req_t req;
    alloc_result_t want;
  } stim_row_t;

  localparam alloc_result_t NO_CHECK = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  sba_pkg::func_t in_func;
  sba_pkg::offs_t in_request_size;
  sba_pkg::align_t in_alignment;
  sba_pkg::addr_t in_address;
  sba_pkg::align_t in_prior_adjust;
  logic out_strobe;
  sba_pkg::status_t out_status;
  sba_pkg::addr_t out_result_address;
  sba_pkg::align_t out_adjust;
  sba_pkg::offs_t out_high_water;
  logic cfg_we;
  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sba_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // allocator model state
  sba_pkg::addr_t base_reg = '0;
  sba_pkg::offs_t cap_reg = '0;
  sba_pkg::offs_t cur_off = '0;
  sba_pkg::offs_t blk_off = '0;
  sba_pkg::offs_t peak_off = '0;
  sba_pkg::offs_t saved_offs [MARKERS];
  int unsigned saved_cnt = 0;

  alloc_result_t results_due [$];
  int errors = 0;
  int sent = 0;
  bit burst = 1'b0;
  int idle_cycles = 0;

  //   setup typed reps mode     func  size  align  address  prior
  stim_row_t dir_rows [29] = '{
    '{0, 1, 1, AM_ABS,  '{sba_pkg::FN_ALLOC, 25'd0, 8'd1, 32'd0, 8'd0},
      '{sba_pkg::ST_OK, 0, 0, 0}},
    '{0, 1, 1, AM_ABS,  '{sba_pkg::FN_ALLOC, 25'd1, 8'd1, 32'd0, 8'd0},
      '{sba_pkg::ST_HEAP, 0, 0, 0}},
    '{0, 1, 1, AM_ABS,  '{sba_pkg::FN_ALLOC_AL, 25'd0, 8'd1, 32'd0, 8'd0},
      '{sba_pkg::ST_HEAP, 0, 0, 0}},
    '{0, 1, 1, AM_ABS,  '{sba_pkg::FN_FREE, 25'd0, 8'd1, 32'd0, 8'd0},
      '{sba_pkg::ST_FREE_OUTSIDE, 0, 0, 0}},
    '{0, 1, 1, AM_ABS,  '{sba_pkg::FN_RESTORE, 25'd0, 8'd1, 32'd0, 8'd0},
      '{sba_pkg::ST_RESTORE_EMPTY, 0, 0, 0}},
    '{1, 1, 1, AM_ABS,  '{sba_pkg::FN_ALLOC, 25'd16, 8'd1, 32'd0, 8'd0},
      '{sba_pkg::ST_OK, 32'h0000_1000, 0, 25'd16}},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC_AL, 25'd8, 8'd128, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC_AL, 25'd5, 8'd0, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC_AL, 25'd5, 8'd3, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC_AL, 25'd3, 8'd255, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_REALLOC, 25'd7, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_BASE, '{sba_pkg::FN_REALLOC, 25'd9, 8'd1, 32'd4, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_LAST, '{sba_pkg::FN_REALLOC, 25'd20, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_REALLOC_AL, 25'd4, 8'd16, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_REALLOC_AL, 25'd6, 8'd4, 32'd5, 8'd5}, NO_CHECK},
    '{0, 0, 1, AM_LAST, '{sba_pkg::FN_REALLOC_AL, 25'd10, 8'd32, 32'd0, 8'd7}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC, 25'd16777216, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,
      '{sba_pkg::FN_REALLOC_AL, 25'h1FF_FFFF, 8'd128, 32'hFFFF_FFFF, 8'hFF}, NO_CHECK},
    '{0, 0, 1, AM_BASE, '{sba_pkg::FN_FREE, 25'd0, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_BASE, '{sba_pkg::FN_FREE, 25'd0, 8'd1, 32'hFFFF_FFFF, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_END,  '{sba_pkg::FN_FREE, 25'd0, 8'd1, 32'hFFFF_FFFF, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_END,  '{sba_pkg::FN_FREE, 25'd0, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_FREE, 25'd0, 8'd1, 32'hFFFF_FFFF, 8'd0}, NO_CHECK},
    '{0, 0, 17, AM_ABS, '{sba_pkg::FN_SAVE, 25'd0, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC, 25'd40, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 2, AM_ABS,  '{sba_pkg::FN_RESTORE, 25'd0, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_LAST, '{sba_pkg::FN_REALLOC, 25'd3, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_RESET, 25'd0, 8'd1, 32'd0, 8'd0}, NO_CHECK},
    '{0, 0, 1, AM_ABS,  '{sba_pkg::FN_ALLOC, 25'd0, 8'd1, 32'd0, 8'd0}, NO_CHECK}
  };

  stack_bump_allocator #(.MARKER_DEPTH(MARKERS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_request_size(in_request_size),
    .in_alignment(in_alignment),
    .in_address(in_address),
    .in_prior_adjust(in_prior_adjust),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_result_address(out_result_address),
    .out_adjust(out_adjust),
    .out_high_water(out_high_water),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit room_for(longint unsigned nbytes);
    return 64'(cur_off) + nbytes <= 64'(cap_reg);
  endfunction

  function automatic bit carve(longint unsigned nbytes, output sba_pkg::addr_t raw);
    raw = '0;
    if (!room_for(nbytes)) return 1'b0;
    raw = base_reg + sba_pkg::addr_t'(cur_off);
    cur_off = sba_pkg::offs_t'(64'(cur_off) + nbytes);
    if (cur_off > peak_off) peak_off = cur_off;
    return 1'b1;
  endfunction

  // grows the last block in place when old points at it, else takes a new one
  function automatic bit regrow(sba_pkg::addr_t old, longint unsigned nbytes,
                                output sba_pkg::addr_t raw);
    sba_pkg::addr_t rel;
    raw = '0;
    if (old == '0) return carve(nbytes, raw);
    if (!room_for(nbytes)) return 1'b0;
    rel = old - base_reg;
    if (rel == sba_pkg::addr_t'(blk_off)) begin
      raw = base_reg + sba_pkg::addr_t'(blk_off);
      cur_off = sba_pkg::offs_t'(64'(blk_off) + nbytes);
    end else begin
      raw = base_reg + sba_pkg::addr_t'(cur_off);
      blk_off = cur_off;
      cur_off = sba_pkg::offs_t'(64'(cur_off) + nbytes);
    end
    if (cur_off > peak_off) peak_off = cur_off;
    return 1'b1;
  endfunction

  function automatic alloc_result_t run_request(sba_pkg::req_t r);
    alloc_result_t res;
    sba_pkg::addr_t raw;
    sba_pkg::addr_t pad;
    longint unsigned nbytes;
    int unsigned al;
    bit ok;
    res = '0;
    raw = '0;
    al = (r.alignment == '0) ? 1 : r.alignment;
    nbytes = 64'(r.request_size);
    case (r.func)
      sba_pkg::FN_ALLOC, sba_pkg::FN_REALLOC: begin
        if (r.func == sba_pkg::FN_ALLOC) ok = carve(nbytes, raw);
        else ok = regrow(r.address, nbytes, raw);
        if (ok) res.addr = raw;
        else res.status = sba_pkg::ST_HEAP;
      end
      sba_pkg::FN_ALLOC_AL, sba_pkg::FN_REALLOC_AL: begin
        if (r.func == sba_pkg::FN_ALLOC_AL || r.address == '0) ok = carve(nbytes + al, raw);
        else ok = regrow(r.address - sba_pkg::addr_t'(r.prior_adjust), nbytes + al, raw);
        if (ok) begin
          // mask is alignment-1 as given, so the pad stays in 1..alignment
          pad = sba_pkg::addr_t'(al) - (raw & sba_pkg::addr_t'(al - 1));
          res.adjust = sba_pkg::align_t'(pad);
          res.addr = raw + pad;
        end else begin
          res.status = sba_pkg::ST_HEAP;
        end
      end
      sba_pkg::FN_FREE: begin
        if (64'(r.address) < 64'(base_reg) ||
            64'(r.address) >= 64'(base_reg) + 64'(cap_reg))
          res.status = sba_pkg::ST_FREE_OUTSIDE;
      end
      sba_pkg::FN_SAVE: begin
        if (saved_cnt >= MARKERS) begin
          res.status = sba_pkg::ST_SAVE_FULL;
        end else begin
          saved_offs[saved_cnt] = cur_off;
          saved_cnt++;
          blk_off = cur_off;
        end
      end
      sba_pkg::FN_RESTORE: begin
        if (saved_cnt == 0) begin
          res.status = sba_pkg::ST_RESTORE_EMPTY;
        end else begin
          saved_cnt--;
          cur_off = saved_offs[saved_cnt];
          blk_off = cur_off;
        end
      end
      default: begin
        // reset request keeps the peak
        cur_off = '0;
        blk_off = '0;
        saved_cnt = 0;
      end
    endcase
    res.high_water = peak_off;
    return res;
  endfunction

  function automatic sba_pkg::addr_t place_address(sba_pkg::req_t r, addr_mode_t m);
    case (m)
      AM_BASE: return base_reg + r.address;
      AM_END: return base_reg + sba_pkg::addr_t'(cap_reg) + r.address;
      AM_LAST: return base_reg + sba_pkg::addr_t'(blk_off) + r.address +
                      ((r.func == sba_pkg::FN_REALLOC_AL) ?
                       sba_pkg::addr_t'(r.prior_adjust) : sba_pkg::addr_t'(0));
      default: return r.address;
    endcase
  endfunction

  function automatic void pick_request(input logic noisy, output sba_pkg::req_t r,
                                       output addr_mode_t m);
    int unsigned roll;
    r.func = sba_pkg::func_t'($urandom);
    r.request_size = sba_pkg::offs_t'($urandom);
    r.alignment = sba_pkg::align_t'($urandom);
    r.address = $urandom;
    r.prior_adjust = sba_pkg::align_t'($urandom);
    m = AM_ABS;
    if (noisy) return;
    roll = $urandom_range(0, 99);
    if (roll < 20) r.func = sba_pkg::FN_ALLOC;
    else if (roll < 35) r.func = sba_pkg::FN_ALLOC_AL;
    else if (roll < 50) r.func = sba_pkg::FN_REALLOC;
    else if (roll < 65) r.func = sba_pkg::FN_REALLOC_AL;
    else if (roll < 75) r.func = sba_pkg::FN_FREE;
    else if (roll < 85) r.func = sba_pkg::FN_SAVE;
    else if (roll < 95) r.func = sba_pkg::FN_RESTORE;
    else r.func = sba_pkg::FN_RESET;
    roll = $urandom_range(0, 99);
    if (roll < 70) r.request_size = sba_pkg::offs_t'($urandom_range(0, 64));
    else if (roll < 90) r.request_size = sba_pkg::offs_t'($urandom_range(0, cap_reg));
    if ($urandom_range(0, 4) != 0) r.alignment = sba_pkg::align_t'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) r.prior_adjust = sba_pkg::align_t'($urandom_range(0, 128));
    case (r.func)
      sba_pkg::FN_REALLOC, sba_pkg::FN_REALLOC_AL: begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          m = AM_LAST;
          r.address = '0;
        end else if (roll < 85) begin
          r.address = '0;
        end else begin
          m = AM_BASE;
          r.address = $urandom_range(0, 4096);
        end
      end
      sba_pkg::FN_FREE: begin
        // hover around both ends of the buffer
        if ($urandom_range(0, 3) != 0) begin
          m = ($urandom_range(0, 1) != 0) ? AM_BASE : AM_END;
          r.address = sba_pkg::addr_t'($urandom_range(0, 8)) - 32'd4;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic issue(input sba_pkg::req_t r, input addr_mode_t m, input logic typed,
                       input alloc_result_t typed_res);
    int gap;
    alloc_result_t due;
    if (sent % 16 == 0) burst = ($urandom_range(0, 2) == 0);
    gap = burst ? 0 : $urandom_range(0, 15);
    r.address = place_address(r, m);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= r.func;
    in_request_size <= r.request_size;
    in_alignment <= r.alignment;
    in_address <= r.address;
    in_prior_adjust <= r.prior_adjust;
    @(posedge clk);
    while (busy) @(posedge clk);
    due = run_request(r);
    results_due.push_back(typed ? typed_res : due);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  task automatic configure(input sba_pkg::addr_t base, input sba_pkg::offs_t cap);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sba_pkg::REG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= sba_pkg::REG_CAP;
    cfg_wdata <= sba_pkg::CFG_DATA_W'(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    base_reg = base;
    cap_reg = cap;
    @(posedge clk);
  endtask

  task automatic flag_field(input string field, input logic [31:0] exp,
                            input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s expected %h actual %h", $time, field, exp, act);
      errors++;
    end
  endtask

  // result beats are sampled with their pre-edge values
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_strobe) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, status %0d addr %h",
                 $time, out_status, out_result_address);
        errors++;
      end else begin
        want = results_due.pop_front();
        flag_field("status", 32'(want.status), 32'(out_status));
        flag_field("result_address", want.addr, out_result_address);
        flag_field("adjust", 32'(want.adjust), 32'(out_adjust));
        flag_field("high_water", 32'(want.high_water), 32'(out_high_water));
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    sba_pkg::req_t r;
    addr_mode_t m;
    int n;
    int stop_at;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= sba_pkg::FN_ALLOC;
    in_request_size <= '0;
    in_alignment <= '0;
    in_address <= '0;
    in_prior_adjust <= '0;
    cfg_we <= 1'b0;
    cfg_index <= sba_pkg::REG_BASE;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.setup) configure(32'h0000_1000, 25'd16777216);
      repeat (row.reps) issue(row.req, row.mode, row.typed, row.want);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: configure(32'h0000_0000, 25'd16777216);
        1: configure(32'hFFFF_FF00, 25'd4096);
        2: configure($urandom, 25'd200);
        3: configure(32'hFFFF_FFFF, 25'd0);
        default: configure($urandom, sba_pkg::offs_t'($urandom_range(0, 16777216)));
      endcase
      stop_at = sent + PHASE_ITEMS;
      while (sent < stop_at) begin
        n = $urandom_range(0, 19);
        if (n < 2) begin
          pick_request(1'b1, r, m);
          issue(r, m, 1'b0, NO_CHECK);
        end else if (n == 2) begin
          // nested markers, sometimes past full and popped past empty
          n = $urandom_range(1, MARKERS + 2);
          repeat (n) begin
            pick_request(1'b0, r, m);
            r.func = sba_pkg::FN_SAVE;
            issue(r, m, 1'b0, NO_CHECK);
          end
          repeat ($urandom_range(0, 3)) begin
            pick_request(1'b0, r, m);
            issue(r, m, 1'b0, NO_CHECK);
          end
          repeat (n + $urandom_range(0, 1)) begin
            pick_request(1'b0, r, m);
            r.func = sba_pkg::FN_RESTORE;
            issue(r, m, 1'b0, NO_CHECK);
          end
        end else if (n == 3 && $urandom_range(0, 3) == 0) begin
          drain();
        end else begin
          pick_request(1'b0, r, m);
          issue(r, m, 1'b0, NO_CHECK);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
